>>> design/rau_pkg.sv
// Package with the shared types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_CMP = 3'd4
   } cmd_type;

   localparam int unsigned WORD_BITS = 64;

   // Request to the shared divider and its answer.
   typedef struct packed {
      logic              start;
      logic [WORD_BITS-1:0] dividend;
      logic [WORD_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_BITS-1:0] quotient;
      logic [WORD_BITS-1:0] remainder;
   } div_rsp_type;

endpackage

>>> design/rational_arithmetic_unit_core.sv
// Top level of the rational arithmetic unit: sequencer around a shared divider and multiplier.
`timescale 1ns / 1ps
// Rational arithmetic unit.
// The request channel carries one word: a command and two fractions a = a_num/a_den and
// b = b_num/b_den. The response channel returns one word per request: the result reduced
// by its gcd with a positive denominator, a three-way compare order and an error status.
// Each operand is reduced by a Euclidean gcd, the cross terms are formed and the result
// is reduced again. Every remainder and quotient comes from one shared bit-serial
// divider. A zero denominator or an unused command gives an error response straight
// from the load state; division by zero answers once both operands are reduced, and
// the time of compare and the other commands is set by the number of Euclidean steps.
// Products use a single registered 32 x 32 multiplier.
// req_tready is high only while the sequencer is idle. The response word is held in an
// output register until rsp_tready is high; meanwhile the next request may be taken,
// and its finished result waits in the sequencer until the output register is free.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
// Only the low OPERAND_BITS bits of each operand field are used, as two's complement.
module rational_arithmetic_unit_core
   import rau_pkg::*;
#(
   parameter int OPERAND_BITS = 32
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // Fields from bit 0: cmd[2:0], a_num[34:3], a_den[66:35], b_num[98:67],
   // b_den[130:99], zero fill to 136 bits.
   input  logic [135:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // Fields from bit 0: res_num[63:0], res_den[126:64], order[128:127],
   // status[129], zero fill to 136 bits.
   output logic [135:0]  rsp_tdata
);

   localparam int MB = OPERAND_BITS;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_GCD_START, S_GCD_WAIT, S_RED_START, S_RED_WAIT,
      S_OP, S_MUL1, S_MUL2, S_COMB, S_OUT
   } state_type;

   // Purpose of the current gcd/reduction pass.
   typedef enum logic [1:0] {
      P_A, P_B, P_Z, P_E
   } pass_type;

   state_type  state_ff;
   pass_type   pass_ff;
   logic [2:0] cmd_ff;
   logic       a_neg_ff, b_neg_ff;
   logic [WORD_BITS-1:0] a_mag_ff, a_den_ff, b_mag_ff, b_den_ff;
   logic [WORD_BITS-1:0] x_ff, y_ff;     // Euclid working pair
   logic [WORD_BITS-1:0] g_ff;           // gcd found
   logic [WORD_BITS-1:0] p_ff, q_ff;     // values to divide by the gcd
   logic [WORD_BITS-1:0] pq_ff, qq_ff;   // their quotients
   logic       red_second_ff;
   logic [WORD_BITS-1:0] t1_ff, t2_ff, den_ff;
   logic [WORD_BITS-1:0] m_a_ff, m_b_ff; // multiplier operands
   logic [WORD_BITS-1:0] m_r_ff;         // multiplier product
   logic [1:0] mul_step_ff;
   logic       r_neg_ff;
   logic       out_valid_ff;
   logic [63:0]  r_num_ff;
   logic [62:0]  r_den_ff;
   logic [1:0]   r_order_ff;
   logic         r_status_ff;
   logic [63:0]  o_num_ff;
   logic [62:0]  o_den_ff;
   logic [1:0]   o_order_ff;
   logic         o_status_ff;

   div_req_type dreq;
   div_rsp_type drsp;

   rau_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Field extraction and sign/magnitude of the low OPERAND_BITS bits.
   function automatic logic [WORD_BITS-1:0] mag_of(input logic [31:0] v);
      logic [MB-1:0] s;
      logic [MB-1:0] m;
      s = v[MB-1:0];
      m = (~s) + MB'(1);
      if (s[MB-1]) return WORD_BITS'(m);
      return WORD_BITS'(s);
   endfunction

   function automatic logic neg_of(input logic [31:0] v);
      return v[MB-1];
   endfunction

   logic [2:0]  in_cmd;
   logic [31:0] in_an, in_ad, in_bn, in_bd;
   assign in_cmd = req_tdata[2:0];
   assign in_an  = req_tdata[34:3];
   assign in_ad  = req_tdata[66:35];
   assign in_bn  = req_tdata[98:67];
   assign in_bd  = req_tdata[130:99];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, o_status_ff, o_order_ff, o_den_ff, o_num_ff};

   // Divider request: Euclid step x % y, or a reduction p / g or q / g.
   always_comb begin
      dreq.start    = 1'b0;
      dreq.dividend = x_ff;
      dreq.divisor  = y_ff;
      if (state_ff == S_GCD_START && y_ff != '0) begin
         dreq.start = 1'b1;
      end else if (state_ff == S_RED_START) begin
         dreq.start    = 1'b1;
         dreq.dividend = red_second_ff ? q_ff : p_ff;
         dreq.divisor  = g_ff;
      end
   end

   logic [WORD_BITS-1:0] sum_w, diff_w;
   logic                 n2_w;
   assign n2_w   = (cmd_ff == CMD_SUB) ? (!b_neg_ff && b_mag_ff != '0) : b_neg_ff;
   assign sum_w  = t1_ff + t2_ff;
   assign diff_w = (t1_ff >= t2_ff) ? t1_ff - t2_ff : t2_ff - t1_ff;

   logic signed [WORD_BITS:0] s1_w, s2_w;
   assign s1_w = a_neg_ff ? -$signed({1'b0, t1_ff}) : $signed({1'b0, t1_ff});
   assign s2_w = b_neg_ff ? -$signed({1'b0, t2_ff}) : $signed({1'b0, t2_ff});

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         pass_ff      <= P_A;
         red_second_ff <= 1'b0;
         mul_step_ff  <= '0;
      end else begin
         // 32 x 32 multiplier, registered.
         m_r_ff <= m_a_ff[31:0] * m_b_ff[31:0];
         // Output register: loaded with a finished result once free, emptied when taken.
         if (state_ff == S_OUT && (!out_valid_ff || rsp_tready)) begin
            out_valid_ff <= 1'b1;
            o_num_ff     <= r_num_ff;
            o_den_ff     <= r_den_ff;
            o_order_ff   <= r_order_ff;
            o_status_ff  <= r_status_ff;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  cmd_ff   <= in_cmd;
                  a_mag_ff <= mag_of(in_an);
                  a_den_ff <= mag_of(in_ad);
                  b_mag_ff <= mag_of(in_bn);
                  b_den_ff <= mag_of(in_bd);
                  a_neg_ff <= neg_of(in_an) ^ neg_of(in_ad);
                  b_neg_ff <= neg_of(in_bn) ^ neg_of(in_bd);
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               if ((a_den_ff == '0) || (b_den_ff == '0) || (cmd_ff > CMD_CMP)) begin
                  r_num_ff <= '0; r_den_ff <= '0; r_order_ff <= '0; r_status_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  pass_ff  <= P_A;
                  x_ff <= a_mag_ff; y_ff <= a_den_ff;
                  p_ff <= a_mag_ff; q_ff <= a_den_ff;
                  state_ff <= S_GCD_START;
               end
            end
            S_GCD_START: begin
               if (y_ff == '0) begin
                  g_ff <= x_ff;
                  red_second_ff <= 1'b0;
                  state_ff <= S_RED_START;
               end else begin
                  state_ff <= S_GCD_WAIT;
               end
            end
            S_GCD_WAIT: begin
               if (drsp.done) begin
                  x_ff <= y_ff;
                  y_ff <= drsp.remainder;
                  state_ff <= S_GCD_START;
               end
            end
            S_RED_START: state_ff <= S_RED_WAIT;
            S_RED_WAIT: begin
               if (drsp.done) begin
                  if (!red_second_ff) begin
                     pq_ff <= drsp.quotient;
                     red_second_ff <= 1'b1;
                     state_ff <= S_RED_START;
                  end else begin
                     qq_ff <= drsp.quotient;
                     red_second_ff <= 1'b0;
                     state_ff <= S_OP;
                  end
               end
            end
            S_OP: begin
               case (pass_ff)
                  P_A: begin
                     a_mag_ff <= pq_ff; a_den_ff <= qq_ff;
                     a_neg_ff <= a_neg_ff && (pq_ff != '0);
                     pass_ff <= P_B;
                     x_ff <= b_mag_ff; y_ff <= b_den_ff;
                     p_ff <= b_mag_ff; q_ff <= b_den_ff;
                     state_ff <= S_GCD_START;
                  end
                  P_B: begin
                     b_mag_ff <= pq_ff; b_den_ff <= qq_ff;
                     b_neg_ff <= b_neg_ff && (pq_ff != '0);
                     if (cmd_ff == CMD_DIV && pq_ff == '0) begin
                        r_num_ff <= '0; r_den_ff <= '0; r_order_ff <= '0;
                        r_status_ff <= 1'b1;
                        state_ff <= S_OUT;
                     end else if (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) begin
                        pass_ff <= P_Z;
                        x_ff <= a_den_ff; y_ff <= qq_ff;
                        p_ff <= a_den_ff; q_ff <= qq_ff;
                        state_ff <= S_GCD_START;
                     end else begin
                        // Products: t1, t2, den (and the second denominator product).
                        mul_step_ff <= 2'd0;
                        if (cmd_ff == CMD_MUL) begin
                           m_a_ff <= a_mag_ff; m_b_ff <= pq_ff;
                        end else begin
                           m_a_ff <= a_mag_ff; m_b_ff <= qq_ff;
                        end
                        state_ff <= S_MUL1;
                     end
                  end
                  P_Z: begin
                     // pq = a.den / z, qq = b.den / z
                     mul_step_ff <= 2'd0;
                     m_a_ff <= qq_ff; m_b_ff <= a_mag_ff;
                     state_ff <= S_MUL1;
                  end
                  default: begin
                     // Final reduction done.
                     r_num_ff <= r_neg_ff && pq_ff != '0 ? 64'(-pq_ff) : pq_ff;
                     r_den_ff <= qq_ff[62:0];
                     r_order_ff <= '0; r_status_ff <= 1'b0;
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_MUL1: state_ff <= S_MUL2;
            S_MUL2: begin
               // m_r_ff holds the product of the operands loaded before S_MUL1.
               case (mul_step_ff)
                  2'd0: begin
                     t1_ff <= m_r_ff;
                     if (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) begin
                        m_a_ff <= pq_ff; m_b_ff <= b_mag_ff;
                     end else if (cmd_ff == CMD_MUL) begin
                        m_a_ff <= a_den_ff; m_b_ff <= b_den_ff;
                     end else if (cmd_ff == CMD_DIV) begin
                        m_a_ff <= a_den_ff; m_b_ff <= b_mag_ff;
                     end else begin
                        m_a_ff <= b_mag_ff; m_b_ff <= a_den_ff;
                     end
                  end
                  2'd1: begin
                     t2_ff <= m_r_ff;
                     m_a_ff <= pq_ff; m_b_ff <= b_den_ff;
                  end
                  default: den_ff <= m_r_ff;
               endcase
               mul_step_ff <= mul_step_ff + 2'd1;
               if (mul_step_ff == 2'd2) state_ff <= S_COMB;
               else state_ff <= S_MUL1;
            end
            S_COMB: begin
               pass_ff <= P_E;
               if (cmd_ff == CMD_CMP) begin
                  r_num_ff <= '0; r_den_ff <= '0; r_status_ff <= 1'b0;
                  r_order_ff <= (s1_w > s2_w) ? 2'b01 : ((s1_w < s2_w) ? 2'b11 : 2'b00);
                  state_ff <= S_OUT;
               end else if (cmd_ff == CMD_MUL || cmd_ff == CMD_DIV) begin
                  r_neg_ff <= a_neg_ff != b_neg_ff;
                  x_ff <= t1_ff; y_ff <= t2_ff; p_ff <= t1_ff; q_ff <= t2_ff;
                  state_ff <= S_GCD_START;
               end else begin
                  if (a_neg_ff == n2_w) begin
                     r_neg_ff <= a_neg_ff;
                     x_ff <= sum_w; p_ff <= sum_w;
                  end else begin
                     r_neg_ff <= (t1_ff >= t2_ff) ? a_neg_ff : n2_w;
                     x_ff <= diff_w; p_ff <= diff_w;
                  end
                  y_ff <= den_ff; q_ff <= den_ff;
                  state_ff <= S_GCD_START;
               end
            end
            S_OUT: begin
               // Wait here until the output register can take the result.
               if (!out_valid_ff || rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("accept while busy");
   a_out_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == S_OUT) else $error("stray response");
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && o_status_ff |-> o_num_ff == '0 && o_den_ff == '0)
      else $error("error word not cleared");
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !o_status_ff && o_order_ff == '0 && o_num_ff != '0 |-> o_den_ff != '0)
      else $error("zero denominator on result");
`endif

endmodule

>>> design/rau_divider.sv
// Bit-serial restoring divider for unsigned 64-bit words, one quotient bit a cycle.
`timescale 1ns / 1ps
module rau_divider
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [WORD_BITS-1:0] quo_ff, quo_in;
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] dsr_ff, dsr_in;
   logic [6:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS:0]   trial;
   logic [WORD_BITS:0]   shifted;

   // One shift and trial subtract per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[WORD_BITS-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
         cnt_in  = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[WORD_BITS]) begin
            rem_in = trial[WORD_BITS-1:0];
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_BITS-1:0];
            quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

`ifndef SYNTHESIS
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff < 7'(WORD_BITS)) else $error("divider count overrun");
`endif

endmodule
